>>> hw/rtl/fair_share_scheduler_assert.svh
// assertion macros used by the scheduler checker
`ifndef FAIR_SHARE_SCHEDULER_ASSERT_SVH
`define FAIR_SHARE_SCHEDULER_ASSERT_SVH

// same-cycle implication, held off while reset is low
`define FSS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("scheduler assertion failed");

// next-cycle implication, held off while reset is low
`define FSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("scheduler assertion failed");

`endif

>>> hw/rtl/fss_pkg.sv
// types and constants of the fair-share scheduler
package fss_pkg;

    localparam int SLOT_W     = 4;
    localparam int WEIGHT_W   = 16;
    localparam int RUN_W      = 32;
    localparam int SLICE_W    = 8;
    localparam int COUNT_W    = 5;
    localparam int ACTION_W   = 2;
    localparam int IN_TDATA_W = 24;
    localparam int RESULT_W   = 12;
    localparam int OUT_TDATA_W = 16;
    localparam logic [SLICE_W-1:0] MAX_SLICE_RST = 8'd5;

    typedef enum logic [ACTION_W-1:0] {
        ACT_ENQUEUE = 2'd0,
        ACT_DEQUEUE = 2'd1,
        ACT_PICK    = 2'd2,
        ACT_TICK    = 2'd3
    } t_action;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_EXEC = 4'b0010,
        ST_SCAN = 4'b0100,
        ST_DONE = 4'b1000
    } t_state;

    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } t_alu_op;

    typedef struct packed {
        t_alu_op          op;
        logic [RUN_W-1:0] a;
        logic [RUN_W-1:0] b;
    } t_alu_req;

    // first member is the top bit, so found lands in bit 0
    typedef struct packed {
        logic               misuse;
        logic [COUNT_W-1:0] queued_count;
        logic               resched;
        logic [SLOT_W-1:0]  chosen_slot;
        logic               found;
    } t_result;

endpackage

>>> hw/rtl/fss_ram.sv
// generic single-port-write, single-port-read ram with registered read
module fss_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> hw/rtl/fss_alu.sv
// shared 32-bit adder for run-time update and run-time compare
module fss_alu (
    input  fss_pkg::t_alu_req          i_req,
    output logic [fss_pkg::RUN_W-1:0]  o_sum
);
    import fss_pkg::*;

    logic             sub;
    logic [RUN_W-1:0] b_eff;

    // one carry chain, operand b inverted with carry-in for subtract
    assign sub   = (i_req.op == ALU_SUB);
    assign b_eff = sub ? ~i_req.b : i_req.b;
    assign o_sum = i_req.a + b_eff + {{(RUN_W-1){1'b0}}, sub};

endmodule

>>> hw/rtl/fair_share_scheduler.sv
// fair-share task scheduler: slot table, sequencer and shared adder
//
//  channel  | direction | payload                               | transfer when
//  ---------+-----------+---------------------------------------+------------------------
//  s_axis   | in        | tuser action, tdata slot/weight       | tvalid & tready
//  m_axis   | out       | tdata found/slot/resched/count/misuse | tvalid & tready
//  cfg      | in        | max_slice                             | wr_en
//
//  enqueue, dequeue and tick go from transfer to result through one ram read,
//  one update of the slot (only tick adds in the shared adder), one load of the output register.
//  pick scans the table: the scan reads one slot a cycle through the
//  single ram read port and compares it in the shared adder.
//  reset clears per-slot valid bits at once, so no clearing pass is needed.
//  a stalled result holds in the output register; the next item can transfer meanwhile
//  and finishes into the output register once it is free.
module fair_share_scheduler #(
    parameter int NUM_SLOTS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [fss_pkg::SLICE_W-1:0]       i_cfg_wr_data,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // [3:0] slot, [19:4] weight, [23:20] zero
    input  logic [fss_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,
    // [1:0] action
    input  logic [fss_pkg::ACTION_W-1:0]      i_s_axis_tuser,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // [0] found, [4:1] chosen_slot, [5] resched, [10:6] queued_count, [11] misuse,
    // [15:12] zero
    output logic [fss_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata
);
    import fss_pkg::*;

    localparam int IW = $clog2(NUM_SLOTS);
    localparam int CW = $clog2(NUM_SLOTS + 1);
    localparam int EW = RUN_W + SLICE_W;
    localparam logic [IW-1:0] LAST_IDX = IW'(NUM_SLOTS - 1);

    t_state               r_state, n_state;
    t_action              r_action;
    logic [IW-1:0]        r_addr;
    logic [WEIGHT_W-1:0]  r_weight;
    logic [SLICE_W-1:0]   r_max_slice;
    logic [NUM_SLOTS-1:0] r_mark;
    logic [NUM_SLOTS-1:0] r_ent_vld;
    logic                 r_rd_vld;
    logic [CW-1:0]        r_count;
    logic [IW-1:0]        r_idx;
    logic                 r_issue_done;
    logic                 r_p_vld;
    logic [IW-1:0]        r_p_idx;
    logic                 r_found;
    logic [IW-1:0]        r_best;
    logic [RUN_W-1:0]     r_best_run;
    logic                 r_resched;
    logic                 r_misuse;
    logic                 r_out_valid;
    t_result              r_out;

    logic                 accept;
    logic [SLOT_W-1:0]    in_slot;
    logic [WEIGHT_W-1:0]  in_weight;
    t_action              in_action;
    logic                 slot_ok;
    logic [IW-1:0]        in_addr;
    logic                 rd_en;
    logic [IW-1:0]        rd_addr;
    logic [EW-1:0]        rd_data;
    logic [RUN_W-1:0]     q_run;
    logic [SLICE_W-1:0]   q_slice;
    t_alu_req             alu_req;
    logic [RUN_W-1:0]     alu_sum;
    logic                 wr_en;
    logic [RUN_W-1:0]     new_run;
    logic [SLICE_W-1:0]   new_slice;
    logic                 set_mark;
    logic                 clr_mark;
    logic                 exec_misuse;
    logic                 exec_resched;
    logic                 cur_mark;
    logic                 out_load;
    t_result              result;

    // input unpacking
    assign in_slot   = i_s_axis_tdata[SLOT_W-1:0];
    assign in_weight = i_s_axis_tdata[SLOT_W +: WEIGHT_W];
    assign in_action = t_action'(i_s_axis_tuser);
    assign slot_ok   = (int'(in_slot) < NUM_SLOTS);
    assign in_addr   = IW'(in_slot);

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    // slot table read: addressed slot on transfer, scan index while picking
    assign rd_en   = (accept && slot_ok) || ((r_state == ST_SCAN) && !r_issue_done);
    assign rd_addr = (r_state == ST_SCAN) ? r_idx : in_addr;

    fss_ram #(
        .WIDTH (EW),
        .DEPTH (NUM_SLOTS)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_addr),
        .i_wr_data ({new_run, new_slice}),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // an entry never written reads as zero
    assign q_run   = r_rd_vld ? rd_data[EW-1:SLICE_W] : '0;
    assign q_slice = r_rd_vld ? rd_data[SLICE_W-1:0] : '0;

    // shared adder: add weight on tick, subtract best run time during scan
    always_comb begin
        alu_req.a = q_run;
        if (r_state == ST_SCAN) begin
            alu_req.op = ALU_SUB;
            alu_req.b  = r_best_run;
        end else begin
            alu_req.op = ALU_ADD;
            alu_req.b  = RUN_W'(r_weight);
        end
    end

    fss_alu u_alu (
        .i_req (alu_req),
        .o_sum (alu_sum)
    );

    // update of the addressed slot
    assign cur_mark = r_mark[r_addr];

    always_comb begin
        wr_en        = 1'b0;
        new_run      = q_run;
        new_slice    = q_slice;
        set_mark     = 1'b0;
        clr_mark     = 1'b0;
        exec_misuse  = 1'b0;
        exec_resched = 1'b0;
        if (r_state == ST_EXEC) begin
            case (r_action)
                ACT_ENQUEUE: begin
                    if (cur_mark) begin
                        exec_misuse = 1'b1;
                    end else begin
                        set_mark = 1'b1;
                        wr_en    = 1'b1;
                        if ((q_slice == '0) || (q_slice > r_max_slice)) begin
                            new_slice = r_max_slice;
                        end
                    end
                end
                ACT_DEQUEUE: begin
                    if (!cur_mark) begin
                        exec_misuse = 1'b1;
                    end else begin
                        clr_mark = 1'b1;
                    end
                end
                ACT_TICK: begin
                    if (q_slice != '0) begin
                        wr_en     = 1'b1;
                        new_slice = q_slice - 1'b1;
                        new_run   = alu_sum;
                    end
                    exec_resched = (new_slice == '0);
                end
                default: begin
                end
            endcase
        end
    end

    // result word
    assign result.found        = r_found;
    assign result.chosen_slot  = SLOT_W'(r_best);
    assign result.resched      = r_resched;
    assign result.queued_count = COUNT_W'(r_count);
    assign result.misuse       = r_misuse;

    assign out_load = (r_state == ST_DONE) && (!r_out_valid || i_m_axis_tready);

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (in_action == ACT_PICK) begin
                        n_state = ST_SCAN;
                    end else if (slot_ok) begin
                        n_state = ST_EXEC;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_EXEC: begin
                n_state = ST_DONE;
            end
            ST_SCAN: begin
                if (r_issue_done && !r_p_vld) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control and table state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_max_slice  <= MAX_SLICE_RST;
            r_mark       <= '0;
            r_ent_vld    <= '0;
            r_count      <= '0;
            r_issue_done <= 1'b0;
            r_p_vld      <= 1'b0;
            r_found      <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_wr_en) begin
                r_max_slice <= i_cfg_wr_data;
            end

            // valid of the read data follows the registered ram read
            if (rd_en) begin
                r_rd_vld <= r_ent_vld[rd_addr];
            end

            // output register
            if (out_load) begin
                r_out_valid <= 1'b1;
                r_out       <= result;
            end else if (r_out_valid && i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_action     <= in_action;
                        r_addr       <= in_addr;
                        r_weight     <= in_weight;
                        r_resched    <= 1'b0;
                        r_misuse     <= 1'b0;
                        r_found      <= 1'b0;
                        r_best       <= '0;
                        r_idx        <= '0;
                        r_issue_done <= 1'b0;
                        r_p_vld      <= 1'b0;
                    end
                end
                ST_EXEC: begin
                    r_misuse  <= exec_misuse;
                    r_resched <= exec_resched;
                    if (wr_en) begin
                        r_ent_vld[r_addr] <= 1'b1;
                    end
                    if (set_mark) begin
                        r_mark[r_addr] <= 1'b1;
                        r_count        <= r_count + CW'(1);
                    end
                    if (clr_mark) begin
                        r_mark[r_addr] <= 1'b0;
                        r_count        <= r_count - CW'(1);
                    end
                end
                ST_SCAN: begin
                    // issue one read a cycle
                    if (!r_issue_done) begin
                        r_idx <= r_idx + 1'b1;
                        if (r_idx == LAST_IDX) begin
                            r_issue_done <= 1'b1;
                        end
                    end
                    r_p_vld <= !r_issue_done;
                    r_p_idx <= r_idx;
                    // keep the queued slot with least run time, lowest index on ties
                    if (r_p_vld && r_mark[r_p_idx]) begin
                        if (!r_found || alu_sum[RUN_W-1]) begin
                            r_found    <= 1'b1;
                            r_best     <= r_p_idx;
                            r_best_run <= q_run;
                        end
                    end
                end
                ST_DONE: begin
                end
                default: begin
                end
            endcase
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(OUT_TDATA_W - RESULT_W){1'b0}}, r_out};

endmodule

>>> hw/rtl/fss_checker.sv
// port-level checks of the fair-share scheduler and their binding
`include "fair_share_scheduler_assert.svh"

module fss_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_s_axis_tvalid,
    input logic                              o_s_axis_tready,
    input logic                              o_m_axis_tvalid,
    input logic                              i_m_axis_tready,
    // [0] found, [4:1] chosen_slot, [5] resched, [10:6] queued_count, [11] misuse
    input logic [fss_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata
);
    import fss_pkg::*;

    // a stalled result stays put
    `FSS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata))

    // the block is busy right after taking an item
    `FSS_ASSERT_NEXT(a_busy_after_transfer, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready, !o_s_axis_tready)

    // nothing found means slot zero
    `FSS_ASSERT_IMPL(a_no_find_slot_zero, i_clk, i_rst_n, o_m_axis_tvalid && !o_m_axis_tdata[0], o_m_axis_tdata[4:1] == 4'd0)

    // a pick that found a slot never reports reschedule or misuse
    `FSS_ASSERT_IMPL(a_pick_flags_clear, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tdata[0], !o_m_axis_tdata[5] && !o_m_axis_tdata[11])

endmodule

bind fair_share_scheduler fss_checker u_fss_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
